>>> sv/chunked_stream_deframer_core_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef CHUNKED_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define CHUNKED_STREAM_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/csd_pkg.sv
// Package with the deframer's types, constants and helper functions.
`default_nettype none

package csd_pkg;

  localparam int SIZE_BITS  = 64;
  localparam int TOTAL_BITS = 48;
  localparam int DECL_BITS  = 48;
  localparam int CMP_BITS   = (TOTAL_BITS > DECL_BITS) ? TOTAL_BITS : DECL_BITS;

  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 3;
  localparam logic [APB_ADDR_BITS-1:0] REG_DECL_LEN = 3'd0;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic [1:0] CLS_FRAMING = 2'd0;
  localparam logic [1:0] CLS_PAYLOAD = 2'd1;
  localparam logic [1:0] CLS_EXT     = 2'd2;
  localparam logic [1:0] CLS_TRAILER = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_FRAMING = 2'd1;
  localparam logic [1:0] ERR_LENGTH  = 2'd2;

  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_EXT     = 4'd1,
    PH_SIZE_LF = 4'd2,
    PH_DATA    = 4'd3,
    PH_DATA_CR = 4'd4,
    PH_DATA_LF = 4'd5,
    PH_TRAILER = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_e;

  // Result of one word, as handed from the parser to the output register.
  typedef struct packed {
    logic [1:0] byte_class;
    logic       chunk_end;
    logic       stream_done;
    logic       error_flag;
    logic [1:0] error_code;
  } res_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/csd_in_if.sv
// Input word channel: valid, ready and one raw body byte.
`default_nettype none

interface csd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> sv/csd_out_if.sv
// Result word channel: valid, ready and the classification of one byte.
`default_nettype none

interface csd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] byte_class;
  logic       chunk_end;
  logic       stream_done;
  logic       error_flag;
  logic [1:0] error_code;

  modport source (output valid, output byte_class, output chunk_end, output stream_done,
                  output error_flag, output error_code, input ready);
  modport sink   (input valid, input byte_class, input chunk_end, input stream_done,
                  input error_flag, input error_code, output ready);
endinterface

`default_nettype wire

>>> sv/csd_parse.sv
// Chunked-body parser: phase machine, size and length counters, error latch.
`default_nettype none

module csd_parse (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [7:0]                   byte_i,
  input  wire logic [csd_pkg::DECL_BITS-1:0] decl_len_i,
  output csd_pkg::res_t                     res_o
);

  csd_pkg::phase_e                    phase_q, phase_d;
  logic [csd_pkg::SIZE_BITS-1:0]      size_q, size_d;
  logic                               saw_q, saw_d;
  logic [csd_pkg::SIZE_BITS-1:0]      owed_q, owed_d;
  logic [csd_pkg::TOTAL_BITS-1:0]     total_q, total_d;
  logic                               lempty_q, lempty_d;
  logic                               lcr_q, lcr_d;
  logic [1:0]                         err_q, err_d;

  logic [4:0] hex;
  logic       is_cr, is_lf, is_semi;
  logic       size_ovf, over_len, owed_last, size_zero, line_blank;

  assign hex        = csd_pkg::hex_decode(byte_i);
  assign is_cr      = (byte_i == csd_pkg::CH_CR);
  assign is_lf      = (byte_i == csd_pkg::CH_LF);
  assign is_semi    = (byte_i == csd_pkg::CH_SEMI);
  assign size_ovf   = |size_q[csd_pkg::SIZE_BITS-1 -: 4];
  assign size_zero  = (size_q == '0);
  assign owed_last  = (owed_q == csd_pkg::SIZE_BITS'(1));
  assign line_blank = lempty_q | lcr_q;
  assign over_len   = (csd_pkg::CMP_BITS'(total_q) >= csd_pkg::CMP_BITS'(decl_len_i)) ||
                      (&total_q);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      csd_pkg::PH_SIZE: begin
        if (hex[4]) begin
          phase_d = size_ovf ? csd_pkg::PH_ERROR : csd_pkg::PH_SIZE;
        end else if (is_semi && saw_q) begin
          phase_d = csd_pkg::PH_EXT;
        end else if (is_cr && saw_q) begin
          phase_d = csd_pkg::PH_SIZE_LF;
        end else begin
          phase_d = csd_pkg::PH_ERROR;
        end
      end
      csd_pkg::PH_EXT: begin
        if (is_cr) phase_d = csd_pkg::PH_SIZE_LF;
      end
      csd_pkg::PH_SIZE_LF: begin
        if (!is_lf) begin
          phase_d = csd_pkg::PH_ERROR;
        end else begin
          phase_d = size_zero ? csd_pkg::PH_TRAILER : csd_pkg::PH_DATA;
        end
      end
      csd_pkg::PH_DATA: begin
        if (over_len) begin
          phase_d = csd_pkg::PH_ERROR;
        end else if (owed_last) begin
          phase_d = csd_pkg::PH_DATA_CR;
        end
      end
      csd_pkg::PH_DATA_CR: begin
        phase_d = is_cr ? csd_pkg::PH_DATA_LF : csd_pkg::PH_ERROR;
      end
      csd_pkg::PH_DATA_LF: begin
        phase_d = is_lf ? csd_pkg::PH_SIZE : csd_pkg::PH_ERROR;
      end
      csd_pkg::PH_TRAILER: begin
        if (is_lf && line_blank) phase_d = csd_pkg::PH_DONE;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Counters, line flags and the per-word result.
  always_comb begin
    size_d   = size_q;
    saw_d    = saw_q;
    owed_d   = owed_q;
    total_d  = total_q;
    lempty_d = lempty_q;
    lcr_d    = lcr_q;
    res_o.byte_class = csd_pkg::CLS_FRAMING;
    res_o.chunk_end  = 1'b0;
    case (phase_q)
      csd_pkg::PH_SIZE: begin
        if (hex[4] && !size_ovf) begin
          size_d = {size_q[csd_pkg::SIZE_BITS-5:0], hex[3:0]};
          saw_d  = 1'b1;
        end
      end
      csd_pkg::PH_EXT: begin
        if (!is_cr) res_o.byte_class = csd_pkg::CLS_EXT;
      end
      csd_pkg::PH_SIZE_LF: begin
        if (is_lf) begin
          owed_d = size_q;
          size_d = '0;
          saw_d  = 1'b0;
          if (size_zero) begin
            lempty_d        = 1'b1;
            lcr_d           = 1'b0;
            res_o.chunk_end = 1'b1;
          end
        end
      end
      csd_pkg::PH_DATA: begin
        if (!over_len) begin
          total_d          = total_q + csd_pkg::TOTAL_BITS'(1);
          owed_d           = owed_q - csd_pkg::SIZE_BITS'(1);
          res_o.byte_class = csd_pkg::CLS_PAYLOAD;
        end
      end
      csd_pkg::PH_DATA_LF: begin
        res_o.chunk_end = is_lf;
      end
      csd_pkg::PH_TRAILER: begin
        res_o.byte_class = csd_pkg::CLS_TRAILER;
        if (is_lf) begin
          if (!line_blank) begin
            lempty_d = 1'b1;
            lcr_d    = 1'b0;
          end
        end else begin
          lcr_d    = lempty_q && is_cr;
          lempty_d = 1'b0;
        end
      end
      default: begin
        res_o.byte_class = csd_pkg::CLS_FRAMING;
      end
    endcase
    // The error code is set on the word that first enters the error phase.
    if (phase_d == csd_pkg::PH_ERROR && phase_q != csd_pkg::PH_ERROR) begin
      err_d = (phase_q == csd_pkg::PH_DATA) ? csd_pkg::ERR_LENGTH : csd_pkg::ERR_FRAMING;
    end else begin
      err_d = err_q;
    end
    res_o.stream_done = (phase_d == csd_pkg::PH_DONE);
    res_o.error_flag  = (err_d != csd_pkg::ERR_NONE);
    res_o.error_code  = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= csd_pkg::PH_SIZE;
      size_q   <= '0;
      saw_q    <= 1'b0;
      owed_q   <= '0;
      total_q  <= '0;
      lempty_q <= 1'b1;
      lcr_q    <= 1'b0;
      err_q    <= csd_pkg::ERR_NONE;
    end else if (step_i) begin
      phase_q  <= phase_d;
      size_q   <= size_d;
      saw_q    <= saw_d;
      owed_q   <= owed_d;
      total_q  <= total_d;
      lempty_q <= lempty_d;
      lcr_q    <= lcr_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/chunked_stream_deframer_core.sv
// Top level of the chunked-body deframer: channels, register port and pipeline.
//
//   Channel   Direction  Handshake            Contents
//   in_s      in         valid/ready          data_byte, one raw body byte per word
//   out_m     out        valid/ready          byte_class, chunk_end, stream_done,
//                                             error_flag, error_code
//   APB       in         psel/penable/pready  declared_length at byte address 0
//
// The block sustains one word per cycle as long as the output side keeps draining.
// A word is accepted into the input register and parsed there; its result is
// registered in the output register as the word moves on, for the sink to take.
// The rate is set by the single parser step between those two registers.
// Reset clears the parser to the size-line phase, the length register to zero and
// both pipeline stages to empty. A stalled output holds its word and back-pressures
// the input register, which in turn drops in_s.ready only when it cannot move.
`default_nettype none

module chunked_stream_deframer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [csd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [csd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [csd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  // Word channels.
  csd_in_if.sink                                 in_s,
  csd_out_if.source                              out_m
);

  // The declared length register. Writes land on the access phase of an APB write.
  logic [csd_pkg::DECL_BITS-1:0] decl_len_q;
  logic                          reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr == csd_pkg::REG_DECL_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_len_q <= '0;
    end else if (reg_wr) begin
      decl_len_q <= pwdata[csd_pkg::DECL_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == csd_pkg::REG_DECL_LEN) begin
      prdata = csd_pkg::APB_DATA_BITS'(decl_len_q);
    end
  end

  // Input register. It is refilled in the same cycle as its word moves on, so a
  // word can be taken every cycle as long as the output side keeps draining.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic       out_free;
  logic       step;

  assign out_free   = !out_vld_q || out_m.ready;
  assign step       = in_vld_q && out_free;
  assign in_s.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_s.ready) begin
      in_vld_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      in_byte_q <= in_s.data_byte;
    end
  end

  // The parser updates its state only on the cycle its word moves to the output.
  csd_pkg::res_t res;

  csd_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .decl_len_i (decl_len_q),
    .res_o      (res)
  );

  // Output register. It holds its word until the sink takes it.
  csd_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_m.valid       = out_vld_q;
  assign out_m.byte_class  = res_q.byte_class;
  assign out_m.chunk_end   = res_q.chunk_end;
  assign out_m.stream_done = res_q.stream_done;
  assign out_m.error_flag  = res_q.error_flag;
  assign out_m.error_code  = res_q.error_code;

endmodule

`default_nettype wire

>>> sv/csd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
`default_nettype none
`include "chunked_stream_deframer_core_defines.svh"

module csd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [1:0] byte_class,
  input wire logic       chunk_end,
  input wire logic       stream_done,
  input wire logic       error_flag,
  input wire logic [1:0] error_code
);

  // The flag and the latched code always agree.
  `CSD_ASSERT_NOW(a_flag_code, clk_i, rst_ni, valid, error_flag == (error_code != csd_pkg::ERR_NONE), "error flag and code disagree")

  // A finished stream and a latched error exclude each other.
  `CSD_ASSERT_NOW(a_done_xor_err, clk_i, rst_ni, valid, !(stream_done && error_flag), "stream done together with an error")

  // A chunk ends only on a framing byte of a healthy, unfinished stream.
  `CSD_ASSERT_NOW(a_chunk_end, clk_i, rst_ni, valid && chunk_end, byte_class == csd_pkg::CLS_FRAMING && !error_flag && !stream_done, "chunk end on a bad word")

  // Bytes after the end or after an error are never classed as content.
  `CSD_ASSERT_NOW(a_dead_class, clk_i, rst_ni, valid && (error_flag || stream_done) && !chunk_end, byte_class == csd_pkg::CLS_FRAMING || byte_class == csd_pkg::CLS_TRAILER, "content class after the end")

  // A stalled result holds.
  `CSD_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid && !ready, valid && $stable(byte_class) && $stable(chunk_end) && $stable(error_code), "stalled result changed")

endmodule

bind chunked_stream_deframer_core csd_checker u_csd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid       (out_m.valid),
  .ready       (out_m.ready),
  .byte_class  (out_m.byte_class),
  .chunk_end   (out_m.chunk_end),
  .stream_done (out_m.stream_done),
  .error_flag  (out_m.error_flag),
  .error_code  (out_m.error_code)
);

`default_nettype wire
